/* hw/rtl/psinv_pkg.sv */
package psinv_pkg;

  localparam int MAX_TERMS_DEF = 1024;
  localparam int COEF_BITS_DEF = 31;
  localparam int TERM_BITS     = 11;
  localparam int IDX_BITS      = 10;

  localparam logic [30:0] MODULUS_RESET = 31'd998244353;
  localparam logic [10:0] TERMS_RESET   = 11'd1024;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_COMPUTE = 2'd1,
    OP_READ    = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOINV   = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  localparam logic [1:0] REG_MODULUS   = 2'd0;
  localparam logic [1:0] REG_IN_TERMS  = 2'd1;
  localparam logic [1:0] REG_OUT_TERMS = 2'd2;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    DP_NOP,
    DP_WR_REDUCE,   // start reduction of the write value
    DP_WR_STORE,    // store reduced write value
    DP_RD_ISSUE,    // issue result store read
    DP_INV_START,   // start reduction of a[0] for Euclid
    DP_INV_STEP,    // start Euclid once a[0] is reduced
    DP_INV_DONE,    // record inverse, b[0]
    DP_ACC_CLEAR,   // clear accumulator for coefficient k
    DP_MAC_ISSUE,   // read a[i] and b[k-i]
    DP_MAC_MUL,     // multiply operands
    DP_MAC_RED,     // reduce product and accumulate
    DP_FIN_MUL,     // multiply -acc by inverse
    DP_FIN_STORE    // store b[k]
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic red_done;   // modular reducer has finished
    logic inv_done;   // Euclid loop has finished
    logic inv_ok;     // gcd equals one
  } dp_stat_t;

endpackage

/* hw/rtl/psinv_if.sv */
interface psinv_in_if #(parameter int IDX_W = 10, parameter int COEF_W = 31);
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [IDX_W-1:0]  index;
  logic [COEF_W-1:0] value;
  modport source (output valid, opcode, index, value, input ready);
  modport sink (input valid, opcode, index, value, output ready);
endinterface

interface psinv_out_if #(parameter int COEF_W = 31);
  logic              valid;
  logic              ready;
  logic [COEF_W-1:0] result_value;
  logic [1:0]        status;
  modport source (output valid, result_value, status, input ready);
  modport sink (input valid, result_value, status, output ready);
endinterface

/* hw/rtl/power_series_inverse_mod_prime_unit.sv */
// Power series inverse modulo a prime. Write coefficients a[i] (opcode 0),
// issue compute (opcode 1), read b[i] (opcode 2); each transaction returns one
// result. Writes pass through the bit-serial reducer before they are stored;
// reads return the stored b[i]. Compute runs extended Euclid for 1/a[0] and
// then out_terms^2/2 multiply-accumulates, bounded by the shared serial
// modular reducer. Registers: modulus at 0, in_terms at 4, out_terms at 8.
module power_series_inverse_mod_prime_unit #(
  parameter int MAX_TERMS = psinv_pkg::MAX_TERMS_DEF,
  parameter int COEF_BITS = psinv_pkg::COEF_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  psinv_in_if.sink    in_ch,
  psinv_out_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import psinv_pkg::*;

  localparam int IW = $clog2(MAX_TERMS);

  logic [COEF_BITS-1:0] modulus, mod_eff, rd_data, wr_value;
  logic [10:0] in_terms, out_terms, n_in, n_out;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [IW-1:0] idx_a, idx_b;
  logic [1:0] status;
  logic sel_rd;

  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus   <= COEF_BITS'(MODULUS_RESET);
      in_terms  <= TERMS_RESET;
      out_terms <= TERMS_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_MODULUS:   modulus   <= pwdata[COEF_BITS-1:0];
        REG_IN_TERMS:  in_terms  <= pwdata[10:0];
        REG_OUT_TERMS: out_terms <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODULUS:   prdata = 32'(modulus);
      REG_IN_TERMS:  prdata = 32'(in_terms);
      REG_OUT_TERMS: prdata = 32'(out_terms);
      default:       prdata = '0;
    endcase
  end

  // hold the write value for the reducer after the transaction
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) wr_value <= in_ch.value;
  end

  assign mod_eff = (modulus < COEF_BITS'(2)) ? COEF_BITS'(2) : modulus;
  assign n_in  = (in_terms == '0) ? 11'd1 :
                 (in_terms > 11'(MAX_TERMS)) ? 11'(MAX_TERMS) : in_terms;
  assign n_out = (out_terms == '0) ? 11'd1 :
                 (out_terms > 11'(MAX_TERMS)) ? 11'(MAX_TERMS) : out_terms;

  psinv_ctrl #(.MAX_TERMS(MAX_TERMS), .IW(IW)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .opcode(in_ch.opcode), .index(in_ch.index[IW-1:0]),
    .n_in(n_in), .n_out(n_out),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .status(status), .sel_rd(sel_rd),
    .cmd(cmd), .idx_a(idx_a), .idx_b(idx_b), .stat(stat)
  );

  psinv_datapath #(.MAX_TERMS(MAX_TERMS), .COEF_BITS(COEF_BITS), .IW(IW)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .idx_a(idx_a), .idx_b(idx_b),
    .wr_value(wr_value), .modulus(mod_eff), .stat(stat), .rd_data(rd_data)
  );

  assign out_ch.status       = status;
  assign out_ch.result_value = sel_rd ? rd_data : '0;
endmodule

/* hw/rtl/psinv_modred.sv */
// Bit-serial remainder of a wide value by the modulus: one quotient bit a cycle.
module psinv_modred #(
  parameter int COEF_BITS = 31
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [2*COEF_BITS-1:0] num,
  input  logic [COEF_BITS-1:0]   modulus,
  output logic                   done,
  output logic [COEF_BITS-1:0]   rem
);
  localparam int NB = 2 * COEF_BITS;
  localparam int CB = $clog2(NB + 1);

  logic [NB-1:0]      shreg;
  logic [COEF_BITS:0] part;
  logic [CB-1:0]      cnt;
  logic               busy;
  logic [COEF_BITS:0] trial;

  always_comb begin
    trial = {part[COEF_BITS-1:0], shreg[NB-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        shreg <= num;
        part  <= '0;
        cnt   <= CB'(NB);
      end else if (busy) begin
        shreg <= shreg << 1;
        if (trial >= {1'b0, modulus}) part <= trial - {1'b0, modulus};
        else part <= trial;
        cnt <= cnt - 1'b1;
        if (cnt == CB'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem = part[COEF_BITS-1:0];
endmodule

/* hw/rtl/psinv_datapath.sv */
// Coefficient stores, accumulator, multiplier, reducer and Euclid registers.
module psinv_datapath #(
  parameter int MAX_TERMS = 1024,
  parameter int COEF_BITS = 31,
  parameter int IW        = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  psinv_pkg::dp_cmd_t       cmd,
  input  logic [IW-1:0]            idx_a,
  input  logic [IW-1:0]            idx_b,
  input  logic [COEF_BITS-1:0]     wr_value,
  input  logic [COEF_BITS-1:0]     modulus,
  output psinv_pkg::dp_stat_t      stat,
  output logic [COEF_BITS-1:0]     rd_data
);
  import psinv_pkg::*;

  localparam int NB = 2 * COEF_BITS;
  localparam int QW = $clog2(COEF_BITS + 1);

  logic [COEF_BITS-1:0] in_mem  [MAX_TERMS];
  logic [COEF_BITS-1:0] res_mem [MAX_TERMS];
  logic [COEF_BITS-1:0] a_q, b_q, acc, inv_val;
  logic [NB-1:0]        prod;
  logic                 mul_q;
  logic                 red_start, red_done;
  logic [NB-1:0]        red_num;
  logic [COEF_BITS-1:0] red_rem;
  // Euclid: remainders plus Bezout coefficient mod m
  logic [COEF_BITS-1:0] r0, r1, t0, t1;
  logic [1:0]           eu_phase;
  logic                 eu_busy, eu_done;
  logic [COEF_BITS:0]   acc_sum;
  logic [COEF_BITS-1:0] neg_acc;

  psinv_modred #(.COEF_BITS(COEF_BITS)) u_red (
    .clk(clk), .rst(rst), .start(red_start), .num(red_num),
    .modulus(modulus), .done(red_done), .rem(red_rem)
  );

  assign acc_sum = {1'b0, acc} + {1'b0, red_rem};
  assign neg_acc = (acc == '0) ? '0 : modulus - acc;

  // reducer source selection
  always_comb begin
    red_start = 1'b0;
    red_num   = prod;
    case (cmd.op)
      DP_WR_REDUCE: begin
        red_start = 1'b1;
        red_num   = NB'(wr_value);
      end
      DP_INV_START: begin
        red_start = 1'b1;
        red_num   = NB'(a_q);
      end
      DP_MAC_RED, DP_FIN_STORE: red_start = 1'b0;
      default: red_start = 1'b0;
    endcase
    // product register was loaded last cycle: reduce it
    if (mul_q) begin
      red_start = 1'b1;
      red_num   = prod;
    end
    // Euclid uses the reducer in phase 0 to reduce the product q*t1 modulo m
    if (eu_busy && eu_phase == 2'd0) begin
      red_start = 1'b1;
      red_num   = prod;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.op == DP_WR_STORE) in_mem[idx_a] <= red_rem;
    if (cmd.op == DP_INV_DONE) res_mem[idx_b] <= t0;
    if (cmd.op == DP_FIN_STORE) res_mem[idx_b] <= red_rem;
    a_q     <= in_mem[idx_a];
    b_q     <= res_mem[idx_b];
    rd_data <= res_mem[idx_a];
  end

  // Euclid with subtraction-based quotient: r0 = q*r1 + rem, quotient derived
  // as bits; to keep the step narrow we use the binary long division loop
  logic [COEF_BITS-1:0] q_acc, rem_w, dv;
  logic [QW-1:0] qbit;
  logic [COEF_BITS:0] trial;
  assign trial = {rem_w, r0[qbit]};

  always_ff @(posedge clk) begin
    if (rst) begin
      eu_busy  <= 1'b0;
      eu_done  <= 1'b0;
      eu_phase <= 2'd0;
      acc      <= '0;
      mul_q    <= 1'b0;
    end else begin
      eu_done <= 1'b0;
      mul_q   <= (cmd.op == DP_MAC_MUL) || (cmd.op == DP_FIN_MUL);
      case (cmd.op)
        DP_ACC_CLEAR: acc <= '0;
        DP_MAC_MUL:   prod <= NB'(a_q) * NB'(b_q);
        DP_FIN_MUL:   prod <= NB'(neg_acc) * NB'(inv_val);
        default: ;
      endcase
      if (cmd.op == DP_MAC_RED && red_done)
        acc <= (acc_sum >= {1'b0, modulus}) ? COEF_BITS'(acc_sum - {1'b0, modulus})
                                            : acc_sum[COEF_BITS-1:0];
      // start Euclid after a[0] reduction
      if (cmd.op == DP_INV_STEP && !eu_busy && red_done) begin
        r0 <= modulus; r1 <= red_rem; t0 <= '0; t1 <= COEF_BITS'(1);
        if (red_rem == '0) eu_done <= 1'b1;
        else begin
          eu_busy  <= 1'b1;
          eu_phase <= 2'd1;
          rem_w    <= '0; q_acc <= '0; qbit <= QW'(COEF_BITS - 1);
        end
      end else if (eu_busy) begin
        case (eu_phase)
          2'd1: begin
            // long division r0 / r1, one bit a cycle
            if (trial >= {1'b0, r1}) begin
              rem_w <= COEF_BITS'(trial - {1'b0, r1});
              q_acc <= q_acc | (COEF_BITS'(1) << qbit);
            end else rem_w <= trial[COEF_BITS-1:0];
            if (qbit == '0) eu_phase <= 2'd2;
            else qbit <= qbit - 1'b1;
          end
          2'd2: begin
            prod     <= NB'(q_acc) * NB'(t1);
            eu_phase <= 2'd0;
          end
          2'd0: eu_phase <= 2'd3;  // reducer running
          default: begin
            if (red_done) begin
              t0 <= t1;
              t1 <= (t0 >= red_rem) ? t0 - red_rem : t0 + (modulus - red_rem);
              r0 <= r1;
              r1 <= rem_w;
              if (rem_w == '0) begin
                eu_busy <= 1'b0;
                eu_done <= 1'b1;
              end else begin
                eu_phase <= 2'd1;
                rem_w <= '0; q_acc <= '0; qbit <= QW'(COEF_BITS - 1);
              end
            end
          end
        endcase
      end
      if (cmd.op == DP_INV_DONE) inv_val <= t0;
    end
  end

  assign stat.red_done = red_done;
  assign stat.inv_done = eu_done;
  assign stat.inv_ok   = (r0 == COEF_BITS'(1));
endmodule

/* hw/rtl/psinv_ctrl.sv */
// Sequencer: handles transactions and runs the recurrence b[k] over the stores.
module psinv_ctrl #(
  parameter int MAX_TERMS = 1024,
  parameter int IW        = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           opcode,
  input  logic [IW-1:0]        index,
  input  logic [10:0]          n_in,
  input  logic [10:0]          n_out,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic                 sel_rd,
  output psinv_pkg::dp_cmd_t   cmd,
  output logic [IW-1:0]        idx_a,
  output logic [IW-1:0]        idx_b,
  input  psinv_pkg::dp_stat_t  stat
);
  import psinv_pkg::*;

  localparam int KW = IW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_WR_RED, S_RD, S_INV_RED, S_INV_RUN, S_INV_FIN,
    S_K_START, S_MAC_ISSUE, S_MAC_WAIT, S_MAC_MUL, S_MAC_RED,
    S_FIN_MUL, S_FIN_RED, S_OUT
  } state_t;

  state_t        state;
  logic [KW-1:0] k, i, vcount;
  logic          noinv;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      noinv     <= 1'b0;
      vcount    <= '0;
      cmd.op    <= DP_NOP;
      sel_rd    <= 1'b0;
    end else begin
      cmd.op <= DP_NOP;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            status <= ST_OK;
            sel_rd <= 1'b0;
            idx_a  <= index;
            case (opcode)
              OP_WRITE: begin
                if ({1'b0, index} < n_in) begin
                  cmd.op <= DP_WR_REDUCE;
                  state  <= S_WR_RED;
                end else begin
                  status <= ST_RANGE; out_valid <= 1'b1;
                end
              end
              OP_COMPUTE: begin
                idx_a  <= '0;
                cmd.op <= DP_NOP;
                state  <= S_INV_RED;
              end
              OP_READ: begin
                if (noinv) begin
                  status <= ST_NOINV; out_valid <= 1'b1;
                end else if ({1'b0, index} >= vcount) begin
                  status <= ST_RANGE; out_valid <= 1'b1;
                end else begin
                  sel_rd <= 1'b1; state <= S_RD;
                end
              end
              default: out_valid <= 1'b1;
            endcase
          end
        end
        S_WR_RED: if (stat.red_done) begin
          cmd.op <= DP_WR_STORE; state <= S_OUT;
        end
        S_RD: state <= S_OUT;
        S_INV_RED: begin
          // a_q holds a[0] in the cycle after the address settles
          cmd.op <= DP_INV_START; state <= S_INV_RUN;
        end
        S_INV_RUN: begin
          cmd.op <= DP_INV_STEP;
          if (stat.inv_done) begin
            cmd.op <= DP_NOP;
            if (stat.inv_ok) begin
              idx_b  <= '0;
              cmd.op <= DP_INV_DONE;
              state  <= S_INV_FIN;
            end else begin
              noinv <= 1'b1; vcount <= '0; status <= ST_NOINV;
              out_valid <= 1'b1; state <= S_IDLE;
            end
          end
        end
        S_INV_FIN: begin
          noinv <= 1'b0;
          k <= KW'(1);
          state <= S_K_START;
        end
        S_K_START: begin
          if (k >= n_out) begin
            vcount <= n_out; out_valid <= 1'b1; state <= S_IDLE;
          end else begin
            cmd.op <= DP_ACC_CLEAR; i <= KW'(1); state <= S_MAC_ISSUE;
          end
        end
        S_MAC_ISSUE: begin
          if (i > k || i >= n_in) begin
            cmd.op <= DP_FIN_MUL; state <= S_FIN_MUL;
          end else begin
            idx_a <= i[IW-1:0];
            idx_b <= IW'(k - i);
            state <= S_MAC_WAIT;
          end
        end
        S_MAC_WAIT: state <= S_MAC_MUL;
        S_MAC_MUL: begin
          cmd.op <= DP_MAC_MUL; state <= S_MAC_RED;
        end
        S_MAC_RED: begin
          cmd.op <= DP_MAC_RED;
          if (stat.red_done) begin
            cmd.op <= DP_MAC_RED; i <= i + 1'b1; state <= S_MAC_ISSUE;
          end
        end
        S_FIN_MUL: begin
          idx_b <= k[IW-1:0];
          cmd.op <= DP_FIN_STORE; state <= S_FIN_RED;
        end
        S_FIN_RED: begin
          if (stat.red_done) begin
            cmd.op <= DP_FIN_STORE; k <= k + 1'b1; state <= S_K_START;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* tb/sv/tb_power_series_inverse_mod_prime_unit.sv */
`timescale 1ns / 100ps

module tb_power_series_inverse_mod_prime_unit;
  import psinv_pkg::*;

  localparam int  NTERMS = MAX_TERMS_DEF;
  localparam int  LIMIT  = 6000000;
  localparam longint unsigned COEF_MASK = (64'd1 << COEF_BITS_DEF) - 1;

  typedef struct {
    logic [30:0] value;
    status_t     status;
  } coef_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  psinv_in_if  in_ch ();
  psinv_out_if out_ch ();

  power_series_inverse_mod_prime_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the block state
  longint unsigned modulus_q, in_terms_q, out_terms_q;
  longint unsigned coef_mem [NTERMS];
  longint unsigned inv_mem [NTERMS];
  bit              coef_written [NTERMS];
  bit              noinv_q;
  int              inv_count;

  coef_result_t pending_q [$];
  int           errors = 0;
  int           cycles = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_req = 0;
  int           hold_cnt = 0;

  function automatic longint unsigned eff_modulus();
    return modulus_q < 2 ? 2 : modulus_q;
  endfunction

  function automatic int clamp_terms(longint unsigned t);
    if (t < 1) return 1;
    if (t > NTERMS) return NTERMS;
    return int'(t);
  endfunction

  // extended Euclid; returns 0 when gcd(a, m) != 1
  function automatic bit mod_inverse(longint unsigned a, longint unsigned m,
                                     output longint unsigned inv);
    longint r0, r1, t0, t1, q, tmp;
    r0 = m; r1 = a % m; t0 = 0; t1 = 1;
    while (r1 != 0) begin
      q = r0 / r1;
      tmp = r0 - q * r1; r0 = r1; r1 = tmp;
      tmp = t0 - q * t1; t0 = t1; t1 = tmp;
    end
    inv = 0;
    if (r0 != 1) return 0;
    inv = t0 < 0 ? t0 + m : t0;
    return 1;
  endfunction

  // truncated reciprocal series by direct recurrence
  function automatic status_t compute_inverse_series();
    longint unsigned m, ia0, acc;
    int n_in, n_out;
    m = eff_modulus();
    n_in = clamp_terms(in_terms_q);
    n_out = clamp_terms(out_terms_q);
    if (!mod_inverse(coef_mem[0] % m, m, ia0)) begin
      noinv_q = 1;
      inv_count = 0;
      return ST_NOINV;
    end
    noinv_q = 0;
    inv_mem[0] = ia0;
    for (int k = 1; k < n_out; k++) begin
      acc = 0;
      for (int i = 1; i <= k && i < n_in; i++)
        acc = (acc + ((coef_mem[i] % m) * (inv_mem[k-i] % m)) % m) % m;
      inv_mem[k] = (((m - acc) % m) * ia0) % m;
    end
    inv_count = n_out;
    return ST_OK;
  endfunction

  function automatic coef_result_t predict_result(opcode_t op, int idx,
                                                  longint unsigned val);
    coef_result_t r;
    r.value = '0;
    r.status = ST_OK;
    case (op)
      OP_WRITE: begin
        if (idx < clamp_terms(in_terms_q)) begin
          coef_mem[idx] = val % eff_modulus();
          coef_written[idx] = 1;
        end else begin
          r.status = ST_RANGE;
        end
      end
      OP_COMPUTE: r.status = compute_inverse_series();
      OP_READ: begin
        if (noinv_q) r.status = ST_NOINV;
        else if (idx >= inv_count) r.status = ST_RANGE;
        else r.value = inv_mem[idx][30:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  // receiver: random stalls, plus long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // result checker; sampled mid-cycle, transaction completes at next rise
  always @(negedge clk) begin
    coef_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result, status", out_ch.status, -1);
      end else begin
        want = pending_q.pop_front();
        if (out_ch.result_value !== want.value)
          report_mismatch("result_value", out_ch.result_value, want.value);
        if (out_ch.status !== want.status)
          report_mismatch("status", out_ch.status, want.status);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[power_series_inverse_mod_prime_unit] ERROR");
      $finish;
    end
  end

  // send one transaction; returns just after the accepting edge
  task automatic send_item(opcode_t op, int idx, longint unsigned val);
    bit got;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.index  <= idx[9:0];
    in_ch.value  <= val[30:0];
    do begin
      @(negedge clk);
      got = in_ch.ready;
      @(posedge clk);
    end while (!got);
    pending_q.push_back(predict_result(op, idx, val));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // register write, only while idle
  task automatic write_reg(logic [1:0] regno, logic [31:0] data);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {regno, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (regno)
      REG_MODULUS:  modulus_q = data & COEF_MASK;
      REG_IN_TERMS: in_terms_q = data & 32'h7ff;
      default:      out_terms_q = data & 32'h7ff;
    endcase
  endtask

  function automatic longint unsigned rand_coef();
    return {$urandom, $urandom} & COEF_MASK;
  endfunction

  // make sure the compute never touches an unwritten coefficient
  task automatic compute_safe();
    int n;
    n = clamp_terms(in_terms_q) < clamp_terms(out_terms_q) ?
        clamp_terms(in_terms_q) : clamp_terms(out_terms_q);
    for (int i = 0; i < n; i++)
      if (!coef_written[i]) send_item(OP_WRITE, i, rand_coef());
    send_item(OP_COMPUTE, $urandom_range(1023), rand_coef());
  endtask

  task automatic test_directed();
    write_reg(REG_OUT_TERMS, 32'd2047);   // clamps to the maximum
    write_reg(REG_OUT_TERMS, 8);
    write_reg(REG_IN_TERMS, 4);
    send_item(OP_READ, 0, 0);             // read before any compute
    send_item(OP_WRITE, 0, COEF_MASK);    // unreduced value
    send_item(OP_WRITE, 1, 0);
    send_item(OP_WRITE, 2, 998244352);
    send_item(OP_WRITE, 3, 12345);
    send_item(OP_WRITE, 4, 7);            // beyond in_terms
    send_item(OP_WRITE, 1023, 7);
    send_item(OP_COMPUTE, 0, 0);
    send_item(OP_READ, 0, 0);
    send_item(OP_READ, 7, 0);
    send_item(OP_READ, 8, 0);             // beyond results
    send_item(OP_READ, 1023, 0);
    send_item(OP_NONE, 1023, COEF_MASK);
    send_item(OP_WRITE, 0, 998244353);    // reduces to zero
    send_item(OP_COMPUTE, 0, 0);
    send_item(OP_READ, 0, 0);             // after failed compute
    // composite modulus: shared factor with a[0]
    write_reg(REG_MODULUS, 6);
    send_item(OP_WRITE, 0, 3);
    send_item(OP_COMPUTE, 0, 0);
    send_item(OP_WRITE, 0, 5);
    send_item(OP_COMPUTE, 0, 0);
    send_item(OP_READ, 5, 0);
    // modulus below two, term count of zero, widest terms
    write_reg(REG_MODULUS, 0);
    write_reg(REG_IN_TERMS, 0);
    send_item(OP_WRITE, 1, 1);
    send_item(OP_WRITE, 0, 3);
    send_item(OP_COMPUTE, 0, 0);
    send_item(OP_READ, 3, 0);
    write_reg(REG_MODULUS, 32'hffff_ffff);
    write_reg(REG_IN_TERMS, 1024);
    write_reg(REG_OUT_TERMS, 12);
    send_item(OP_WRITE, 1023, COEF_MASK);
    compute_safe();
    send_item(OP_READ, 11, 0);
  endtask

  task automatic random_config();
    longint unsigned mods [7] = '{2, 3, 7, 65537, 998244353, 1000000007,
                                  2147483647};
    if ($urandom_range(3) == 0) write_reg(REG_MODULUS, $urandom);
    else write_reg(REG_MODULUS, mods[$urandom_range(6)]);
    case ($urandom_range(3))
      0:       write_reg(REG_IN_TERMS, $urandom_range(1, 1024));
      1:       write_reg(REG_IN_TERMS, $urandom_range(0, 2047));
      default: write_reg(REG_IN_TERMS, $urandom_range(1, 16));
    endcase
    write_reg(REG_OUT_TERMS, $urandom_range(1, 12));
  endtask

  task automatic test_random(int idle, int stall, int count);
    int sel, lim;
    opcode_t op;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    random_config();
    compute_safe();
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (n % 80 == 79) random_config();
      if (sel < 3) begin
        compute_safe();
      end else if (sel < 45) begin
        lim = clamp_terms(in_terms_q);
        send_item(OP_WRITE, $urandom_range(lim > 16 ? 15 : lim - 1), rand_coef());
      end else if (sel < 88) begin
        lim = inv_count > 0 ? inv_count - 1 : 0;
        send_item(OP_READ, $urandom_range(lim), rand_coef());
      end else begin
        op = opcode_t'($urandom_range(3));
        if (op == OP_COMPUTE) compute_safe();
        else send_item(op, $urandom_range(1023), rand_coef());
      end
    end
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // receiver holds off while reads keep coming, then sender drains
  task automatic test_backpressure();
    hold_req = 400;
    for (int n = 0; n < 60; n++) send_item(OP_READ, $urandom_range(15), 0);
    wait_drained();
    for (int n = 0; n < 20; n++) send_item(OP_READ, $urandom_range(15), 0);
    wait_drained();
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.opcode = OP_NONE;
    in_ch.index  = '0;
    in_ch.value  = '0;
    modulus_q    = MODULUS_RESET;
    in_terms_q   = TERMS_RESET;
    out_terms_q  = TERMS_RESET;
    noinv_q      = 0;
    inv_count    = 0;
    for (int i = 0; i < NTERMS; i++) begin
      coef_written[i] = 0;
      coef_mem[i] = 0;
      inv_mem[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(0, 0, 230);
    test_random(75, 0, 230);
    test_random(0, 75, 230);
    test_random(30, 30, 230);
    test_backpressure();

    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("[power_series_inverse_mod_prime_unit] OK");
    end else begin
      $display("[power_series_inverse_mod_prime_unit] ERROR");
    end
    $finish;
  end

endmodule
